// ----- rtl/hsec_pkg.sv -----
`timescale 1ns / 1ps

package hsec_pkg;

	localparam int MAX_DATA_BITS = 32;
	localparam int DATA_WIDTH    = 32;
	localparam int CODE_WIDTH    = 38;
	localparam int LEN_WIDTH     = 6;
	localparam int SYN_WIDTH     = 6;
	localparam int PAR_WIDTH     = 3;
	localparam int DIDX_WIDTH    = $clog2(DATA_WIDTH);
	localparam int CIDX_WIDTH    = $clog2(CODE_WIDTH);

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_CHECK  = 1'b1;

	localparam logic [LEN_WIDTH-1:0] DATA_BITS_RESET = LEN_WIDTH'(32);

	// codeword with its length after the placement stage
	typedef struct packed {
		logic                  op;
		logic [CODE_WIDTH-1:0] code;
		logic [LEN_WIDTH-1:0]  n;
	} place_t;

	// codeword plus parity group results after the syndrome stage
	typedef struct packed {
		logic                  op;
		logic [CODE_WIDTH-1:0] code;
		logic [LEN_WIDTH-1:0]  n;
		logic [SYN_WIDTH-1:0]  syn;
	} synd_t;

	// clamp the configured length into 1..MAX_DATA_BITS
	function automatic logic [LEN_WIDTH-1:0] eff_len(input logic [LEN_WIDTH-1:0] bits);
		logic [LEN_WIDTH-1:0] d;
		begin
			d = bits;
			if (d == '0) d = LEN_WIDTH'(1);
			if (int'(d) > MAX_DATA_BITS) d = LEN_WIDTH'(MAX_DATA_BITS);
			return d;
		end
	endfunction

	// least r with 2^r >= d + r + 1
	function automatic logic [PAR_WIDTH-1:0] parity_count(input logic [LEN_WIDTH-1:0] d);
		int r;
		begin
			r = 0;
			for (int i = 0; i < 7; i++) begin
				if ((1 << r) < int'(d) + r + 1) r = r + 1;
			end
			return PAR_WIDTH'(r);
		end
	endfunction

	function automatic logic is_pow2(input int v);
		begin
			return (v != 0) && ((v & (v - 1)) == 0);
		end
	endfunction

	// data bit held at a code position, -1 at parity positions
	function automatic int data_index(input int pos);
		int j;
		begin
			j = 0;
			for (int p = 1; p < pos; p++) begin
				if (!is_pow2(p)) j = j + 1;
			end
			return is_pow2(pos) ? -1 : j;
		end
	endfunction

endpackage

// ----- rtl/hamming_sec_encode_check.sv -----
`timescale 1ns / 1ps
// channel   handshake              payload
// request   req_valid / req_stall  operation, data_in, received_code
// response  rsp_valid / rsp_stall  code_out, syndrome, error_found, uncorrectable
// config    cfg_valid / cfg_ready  cfg_data (data_bits)
//
// rsp_valid rises once a request transaction has passed through the three register
// stages: placement, parity xor trees, correction; one word per cycle while rsp_stall is low
// arst_n clears all stage valids and sets data_bits to 32; cfg_ready is always high
// rsp_stall freezes only full stages; bubbles close up, req_stall is high only while
// all three are full and rsp_stall is high

module hamming_sec_encode_check import hsec_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [LEN_WIDTH-1:0]  cfg_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic                  operation,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [CODE_WIDTH-1:0] received_code,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [CODE_WIDTH-1:0] code_out,
	output logic [SYN_WIDTH-1:0]  syndrome,
	output logic                  error_found,
	output logic                  uncorrectable
);

	logic [LEN_WIDTH-1:0] data_bits_q;
	logic                 valid_s1;
	logic                 valid_s2;
	logic                 valid_s3;
	logic                 adv1;
	logic                 adv2;
	logic                 adv3;
	place_t               place_s1;
	synd_t                synd_s2;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= DATA_BITS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			data_bits_q <= cfg_data;
		end
	end

	// a stage moves when it is empty or the one after it moves
	assign adv3      = !valid_s3 || !rsp_stall;
	assign adv2      = !valid_s2 || adv3;
	assign adv1      = !valid_s1 || adv2;
	assign req_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= req_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
		end
	end

	hsec_place u_place (
		.clk           (clk),
		.en            (adv1),
		.operation     (operation),
		.data_in       (data_in),
		.received_code (received_code),
		.data_bits     (data_bits_q),
		.place_s1      (place_s1)
	);

	hsec_syndrome u_syndrome (
		.clk      (clk),
		.en       (adv2),
		.place_s1 (place_s1),
		.synd_s2  (synd_s2)
	);

	hsec_correct u_correct (
		.clk     (clk),
		.en      (adv3),
		.synd_s2 (synd_s2),
		.code_s3 (code_out),
		.syn_s3  (syndrome),
		.err_s3  (error_found),
		.bad_s3  (uncorrectable)
	);

	assign rsp_valid = valid_s3;

`ifndef ASSERT_OFF
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && valid_s3 && rsp_stall))
		else $error("request stalled with a free stage");

	a_bad_err: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && uncorrectable) |-> error_found)
		else $error("uncorrectable without error_found");

	a_err_syn: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (error_found == (syndrome != '0)))
		else $error("error_found disagrees with syndrome");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !valid_s3) |=> valid_s3)
		else $error("stage 2 transaction did not advance into empty stage 3");
`endif

endmodule

// ----- rtl/hsec_place.sv -----
`timescale 1ns / 1ps

module hsec_place import hsec_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  logic                  operation,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [CODE_WIDTH-1:0] received_code,
	input  logic [LEN_WIDTH-1:0]  data_bits,
	output place_t                place_s1
);

	logic [LEN_WIDTH-1:0]  d;
	logic [PAR_WIDTH-1:0]  r;
	logic [LEN_WIDTH-1:0]  n;
	logic [DATA_WIDTH-1:0] data_m;
	logic [CODE_WIDTH-1:0] enc;
	logic [CODE_WIDTH-1:0] rcv;
	int                    j;

	always_comb begin
		d = eff_len(data_bits);
		r = parity_count(d);
		n = LEN_WIDTH'(d + LEN_WIDTH'(r));
		for (int i = 0; i < DATA_WIDTH; i++) begin
			data_m[i] = data_in[i] && (i < int'(d));
		end
		for (int i = 0; i < CODE_WIDTH; i++) begin
			rcv[i] = received_code[i] && (i < int'(n));
		end
		// scatter data bits to the non-power-of-two positions, parity slots stay 0
		enc = '0;
		j = 0;
		for (int p = 1; p <= CODE_WIDTH; p++) begin
			j = data_index(p);
			if (j >= 0 && j < DATA_WIDTH) enc[p-1] = data_m[DIDX_WIDTH'(j)];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			place_s1.op   <= operation;
			place_s1.code <= (operation == OP_CHECK) ? rcv : enc;
			place_s1.n    <= n;
		end
	end

endmodule

// ----- rtl/hsec_syndrome.sv -----
`timescale 1ns / 1ps

module hsec_syndrome import hsec_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  place_t place_s1,
	output synd_t  synd_s2
);

	logic [SYN_WIDTH-1:0] par;

	// one xor tree per parity group; positions above n are already zero
	always_comb begin
		for (int k = 0; k < SYN_WIDTH; k++) begin
			par[k] = 1'b0;
			for (int p = 1; p <= CODE_WIDTH; p++) begin
				if (((p >> k) & 1) == 1) par[k] = par[k] ^ place_s1.code[p-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			synd_s2.op   <= place_s1.op;
			synd_s2.code <= place_s1.code;
			synd_s2.n    <= place_s1.n;
			synd_s2.syn  <= par;
		end
	end

endmodule

// ----- rtl/hsec_correct.sv -----
`timescale 1ns / 1ps

module hsec_correct import hsec_pkg::*; (
	input  logic                  clk,
	input  logic                  en,
	input  synd_t                 synd_s2,
	output logic [CODE_WIDTH-1:0] code_s3,
	output logic [SYN_WIDTH-1:0]  syn_s3,
	output logic                  err_s3,
	output logic                  bad_s3
);

	logic [CODE_WIDTH-1:0] enc;
	logic [CODE_WIDTH-1:0] fixed;
	logic                  err;
	logic                  bad;

	always_comb begin
		// on encode the group parities are the parity bits themselves
		enc = synd_s2.code;
		for (int k = 0; k < SYN_WIDTH; k++) begin
			if ((1 << k) <= CODE_WIDTH) enc[CIDX_WIDTH'((1 << k) - 1)] = synd_s2.syn[k];
		end
		err = (synd_s2.syn != '0);
		bad = err && (synd_s2.syn > synd_s2.n);
		fixed = synd_s2.code;
		for (int i = 0; i < CODE_WIDTH; i++) begin
			if (err && !bad && synd_s2.syn == SYN_WIDTH'(i + 1)) fixed[i] = ~synd_s2.code[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (synd_s2.op == OP_CHECK) begin
				code_s3 <= fixed;
				syn_s3  <= synd_s2.syn;
				err_s3  <= err;
				bad_s3  <= bad;
			end else begin
				code_s3 <= enc;
				syn_s3  <= '0;
				err_s3  <= 1'b0;
				bad_s3  <= 1'b0;
			end
		end
	end

endmodule

// ----- dv/hsec_codec_checker.sv -----
`timescale 1ns / 1ps

module hsec_codec_checker import hsec_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [LEN_WIDTH-1:0]  cfg_data,
	input  logic                  req_valid,
	input  logic                  req_stall,
	input  logic                  operation,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [CODE_WIDTH-1:0] received_code,
	input  logic                  rsp_valid,
	input  logic                  rsp_stall,
	input  logic [CODE_WIDTH-1:0] code_out,
	input  logic [SYN_WIDTH-1:0]  syndrome,
	input  logic                  error_found,
	input  logic                  uncorrectable,
	output int                    in_flight,
	output int                    code_len,
	output int                    fails
);

	typedef struct packed {
		logic [CODE_WIDTH-1:0] code;
		logic [SYN_WIDTH-1:0]  syn;
		logic                  err;
		logic                  bad;
	} codec_word_t;

	codec_word_t          codec_q[$];
	logic [LEN_WIDTH-1:0] len_reg;
	int                   mismatches = 0;

	// out-of-range lengths clamp into 1..MAX_DATA_BITS
	function automatic int data_len(input logic [LEN_WIDTH-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > MAX_DATA_BITS) begin
			return MAX_DATA_BITS;
		end
		return int'(v);
	endfunction

	function automatic int parity_len(input int d);
		int r;
		r = 0;
		while ((1 << r) < d + r + 1) r++;
		return r;
	endfunction

	function automatic codec_word_t hamming_codec(input logic op,
			input logic [DATA_WIDTH-1:0] data, input logic [CODE_WIDTH-1:0] rx,
			input logic [LEN_WIDTH-1:0] len);
		int                    d;
		int                    r;
		int                    n;
		int                    j;
		logic                  p;
		logic [CODE_WIDTH-1:0] cw;
		logic [SYN_WIDTH-1:0]  s;
		codec_word_t           o;
		d  = data_len(len);
		r  = parity_len(d);
		n  = d + r;
		cw = '0;
		s  = '0;
		o  = '0;
		if (op == OP_ENCODE) begin
			j = 0;
			for (int pos = 1; pos <= n; pos++) begin
				if ((pos & (pos - 1)) != 0) begin
					cw[pos - 1] = data[j];
					j++;
				end
			end
			// a parity position sits in its own group only, so fill them in turn
			for (int k = 0; k < r; k++) begin
				p = 1'b0;
				for (int pos = 1; pos <= n; pos++) begin
					if (((pos >> k) & 1) != 0) p ^= cw[pos - 1];
				end
				cw[(1 << k) - 1] = p;
			end
		end else begin
			// syndrome is the xor of the positions holding a one
			for (int pos = 1; pos <= n; pos++) begin
				cw[pos - 1] = rx[pos - 1];
				if (rx[pos - 1]) s ^= SYN_WIDTH'(pos);
			end
			if (s != '0) begin
				o.err = 1'b1;
				if (int'(s) > n) begin
					o.bad = 1'b1;
				end else begin
					cw[int'(s) - 1] = ~cw[int'(s) - 1];
				end
			end
		end
		o.code = cw;
		o.syn  = s;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		codec_word_t w;
		if (!arst_n) begin
			len_reg = DATA_BITS_RESET;
			codec_q.delete();
			in_flight <= 0;
			code_len  <= data_len(DATA_BITS_RESET) + parity_len(data_len(DATA_BITS_RESET));
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (codec_q.size() == 0) begin
					$error("response transaction with nothing outstanding");
					mismatches++;
				end else begin
					w = codec_q.pop_front();
					if (code_out !== w.code) begin
						$error("code_out: expected %h, got %h", w.code, code_out);
						mismatches++;
					end
					if (syndrome !== w.syn) begin
						$error("syndrome: expected %0d, got %0d", w.syn, syndrome);
						mismatches++;
					end
					if (error_found !== w.err) begin
						$error("error_found: expected %b, got %b", w.err, error_found);
						mismatches++;
					end
					if (uncorrectable !== w.bad) begin
						$error("uncorrectable: expected %b, got %b", w.bad, uncorrectable);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				codec_q.push_back(hamming_codec(operation, data_in, received_code, len_reg));
			end
			if (cfg_valid && cfg_ready) begin
				len_reg = cfg_data;
				code_len <= data_len(cfg_data) + parity_len(data_len(cfg_data));
			end
			in_flight <= codec_q.size();
			fails     <= mismatches;
		end
	end

endmodule

// ----- dv/tb_hamming_sec_encode_check.sv -----
`timescale 1ns / 1ps

module tb_hamming_sec_encode_check;
	import hsec_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int POOL_DEPTH  = 16;
	localparam int PHASES      = 18;
	localparam int PER_PHASE   = 34;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [LEN_WIDTH-1:0]  cfg_data      = '0;
	logic                  req_valid     = 1'b0;
	logic                  req_stall;
	logic                  operation     = OP_ENCODE;
	logic [DATA_WIDTH-1:0] data_in       = '0;
	logic [CODE_WIDTH-1:0] received_code = '0;
	logic                  rsp_valid;
	logic                  rsp_stall     = 1'b0;
	logic [CODE_WIDTH-1:0] code_out;
	logic [SYN_WIDTH-1:0]  syndrome;
	logic                  error_found;
	logic                  uncorrectable;

	int in_flight;
	int code_len;
	int chk_fails;
	int cycles     = 0;
	int stall_hold = 0;
	bit quiet      = 1'b0;

	// recent valid codewords seen on the response side, reused as check input
	logic [CODE_WIDTH-1:0] pool [POOL_DEPTH];
	int                    pool_n  = 0;
	int                    pool_wr = 0;

	int len_plan [14] = '{32, 1, 0, 63, 2, 3, 4, 5, 11, 12, 26, 27, 31, 33};

	always #2 clk = ~clk;

	hamming_sec_encode_check u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.data_in       (data_in),
		.received_code (received_code),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.code_out      (code_out),
		.syndrome      (syndrome),
		.error_found   (error_found),
		.uncorrectable (uncorrectable)
	);

	hsec_codec_checker u_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.operation     (operation),
		.data_in       (data_in),
		.received_code (received_code),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.code_out      (code_out),
		.syndrome      (syndrome),
		.error_found   (error_found),
		.uncorrectable (uncorrectable),
		.in_flight     (in_flight),
		.code_len      (code_len),
		.fails         (chk_fails)
	);

	// mostly back to back, some short gaps, a few long ones
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_hold > 0) begin
			stall_hold = stall_hold - 1;
		end else if (quiet) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(0, 99) < 30);
			stall_hold = idle_cycles();
		end
	end

	// a new length empties the pool
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready) begin
			pool_n <= 0;
		end else if (arst_n && rsp_valid && !rsp_stall && !uncorrectable) begin
			pool[pool_wr] <= code_out;
			pool_wr       <= (pool_wr + 1) % POOL_DEPTH;
			pool_n        <= (pool_n < POOL_DEPTH) ? pool_n + 1 : POOL_DEPTH;
		end
	end

	task automatic send_word(input logic op, input logic [DATA_WIDTH-1:0] d,
			input logic [CODE_WIDTH-1:0] rx);
		int gap;
		req_valid     <= 1'b1;
		operation     <= op;
		data_in       <= d;
		received_code <= rx;
		do @(posedge clk); while (req_stall);
		gap = quiet ? 0 : idle_cycles();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and wait until every transaction has come back
	task automatic settle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (in_flight != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_len(input logic [LEN_WIDTH-1:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_word();
		logic [63:0]           t;
		logic [CODE_WIDTH-1:0] rx;
		logic [CODE_WIDTH-1:0] w;
		logic [DATA_WIDTH-1:0] dw;
		int                    r;
		int                    n;
		n  = code_len;
		t  = {$urandom(), $urandom()};
		rx = t[CODE_WIDTH-1:0];
		dw = $urandom();
		r  = $urandom_range(0, 99);
		if (r < 8) begin
			dw = '1;
		end else if (r < 14) begin
			dw = '0;
		end
		if ($urandom_range(0, 99) < 35) begin
			send_word(OP_ENCODE, dw, rx);
		end else begin
			if (pool_n > 0 && $urandom_range(0, 99) < 65) begin
				w = pool[$urandom_range(0, pool_n - 1)];
				r = $urandom_range(0, 9);
				// clean, single error or double error
				if (r >= 3) w[$urandom_range(0, n - 1)] ^= 1'b1;
				if (r >= 8) w[$urandom_range(0, n - 1)] ^= 1'b1;
				// junk in the bits past the code length
				if ($urandom_range(0, 4) == 0) w = w | (rx & ({CODE_WIDTH{1'b1}} << n));
				rx = w;
			end
			send_word(OP_CHECK, dw, rx);
		end
	endtask

	initial begin
		int v;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset length of 32 data bits, 38 code positions
		send_word(OP_ENCODE, 32'h0000_0000, 38'h3F_FFFF_FFFF);
		send_word(OP_ENCODE, 32'hFFFF_FFFF, 38'h00_0000_0000);
		send_word(OP_ENCODE, 32'hAAAA_AAAA, 38'h15_5555_5555);
		send_word(OP_ENCODE, 32'h5555_5555, 38'h2A_AAAA_AAAA);
		send_word(OP_ENCODE, 32'h0000_0001, 38'h00_0000_0000);
		send_word(OP_ENCODE, 32'h8000_0000, 38'h00_0000_0000);
		send_word(OP_CHECK, 32'hFFFF_FFFF, 38'h00_0000_0000);
		send_word(OP_CHECK, 32'h0000_0000, 38'h3F_FFFF_FFFF);
		// single errors on the all-zero codeword, parity and data positions
		send_word(OP_CHECK, 32'h0000_0000, 38'h00_0000_0001);
		send_word(OP_CHECK, 32'h0000_0000, 38'h00_0000_0002);
		send_word(OP_CHECK, 32'h0000_0000, 38'h00_0000_0004);
		send_word(OP_CHECK, 32'h0000_0000, 38'h00_0000_0008);
		send_word(OP_CHECK, 32'h0000_0000, 38'h00_8000_0000);
		send_word(OP_CHECK, 32'h0000_0000, 38'h20_0000_0000);
		// positions 32 and 8 give a syndrome past the code length
		send_word(OP_CHECK, 32'h0000_0000, 38'h00_8000_0080);
		// double error, miscorrected
		send_word(OP_CHECK, 32'h0000_0000, 38'h10_0000_0001);
		send_word(OP_CHECK, 32'h1234_5678, 38'h2A_AAAA_AAAA);
		send_word(OP_CHECK, 32'h8765_4321, 38'h15_5555_5555);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			v = (ph < 14) ? len_plan[ph] : $urandom_range(0, 63);
			write_len(LEN_WIDTH'(v));
			quiet = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PER_PHASE; i++) begin
				if (i == PER_PHASE / 2 && (ph == 1 || $urandom_range(0, 3) == 0)) begin
					settle();
				end
				random_word();
			end
			quiet = 1'b0;
			settle();
		end

		repeat (10) @(posedge clk);
		if (chk_fails == 0 && in_flight == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
